@@ hdl/ctks_pkg.sv @@
package ctks_pkg;

	localparam int DEF_MAX_ENTRIES = 256;
	localparam int DEF_MAX_DIM     = 1024;
	localparam int DEF_MAX_K       = 16;

	localparam logic [10:0]        DIM_RESET    = 11'd768;
	localparam logic [4:0]         TOPK_RESET   = 5'd4;
	localparam logic signed [15:0] MINSIM_RESET = 16'sd0;

	localparam logic [1:0] FN_WRITE  = 2'd0;
	localparam logic [1:0] FN_REMOVE = 2'd1;
	localparam logic [1:0] FN_CLEAR  = 2'd2;
	localparam logic [1:0] FN_QUERY  = 2'd3;

	localparam logic [1:0] CFG_DIM    = 2'd0;
	localparam logic [1:0] CFG_TOPK   = 2'd1;
	localparam logic [1:0] CFG_MINSIM = 2'd2;

	// 1.0 in Q1.15
	localparam logic [15:0]        SIM_ONE  = 16'd32768;
	localparam logic signed [15:0] SIM_MAX  = 16'sd32767;
	localparam logic signed [15:0] SIM_ZERO = 16'sd0;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DOT,
		ST_MULP,
		ST_MULR,
		ST_ROOT,
		ST_INSERT,
		ST_EMIT
	} ctks_state_t;

	typedef struct packed {
		logic take;
		logic search_init;
		logic scan_next;
		logic dot_start;
		logic mul_start;
		logic mul_sel_r;
		logic root_start;
		logic insert;
		logic emit_load;
	} ctks_cmd_t;

	typedef struct packed {
		logic qry_last;
		logic qry_ok;
		logic ent_valid;
		logic ent_last;
		logic dot_busy;
		logic zero_norm;
		logic mul_busy;
		logic root_busy;
		logic out_free;
		logic emit_last;
	} ctks_sts_t;

endpackage

@@ hdl/cosine_topk_vector_search_core.sv @@
// Cosine top-k search over a table of MAX_ENTRIES Q1.15 vectors. Stored and query
// vectors stream in one element per transfer, one transfer per cycle while no search
// runs; the final query element starts a search (or, for a malformed query, goes
// straight to the results) and holds cmd_stall high until the last result is loaded.
// The search walks every slot; each valid slot takes a dot product (one memory read
// per cycle), two products in the shift-add multiplier, a root search and an insert;
// zero-norm slots skip the multiplier and the root search. Results then leave at one
// per cycle while res_stall is low, best first, through a registered output.
// Configuration writes are always accepted (cfg_ready stays high).
module cosine_topk_vector_search_core import ctks_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int MAX_DIM     = DEF_MAX_DIM,
	parameter int MAX_K       = DEF_MAX_K
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  logic [1:0]         func,
	input  logic [7:0]         entry_index,
	input  logic [9:0]         element_index,
	input  logic signed [15:0] element_value,
	input  logic               last_element,
	output logic               res_valid,
	input  logic               res_stall,
	output logic [7:0]         match_index,
	output logic signed [15:0] similarity,
	output logic [16:0]        distance,
	output logic [3:0]         rank,
	output logic               found,
	output logic               last_result
);

	ctks_cmd_t ctl;
	ctks_sts_t sts;

	assign cfg_ready = 1'b1;

	ctks_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	ctks_dp #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.MAX_DIM     (MAX_DIM),
		.MAX_K       (MAX_K)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.func          (func),
		.entry_index   (entry_index),
		.element_index (element_index),
		.element_value (element_value),
		.last_element  (last_element),
		.ctl           (ctl),
		.sts           (sts),
		.res_stall     (res_stall),
		.res_valid     (res_valid),
		.match_index   (match_index),
		.similarity    (similarity),
		.distance      (distance),
		.rank          (rank),
		.found         (found),
		.last_result   (last_result)
	);

endmodule

@@ hdl/ctks_ctrl.sv @@
module ctks_ctrl import ctks_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_stall,
	input  ctks_sts_t sts,
	output ctks_cmd_t ctl
);

	ctks_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && sts.qry_last) state_d = sts.qry_ok ? ST_SCAN : ST_EMIT;
			end
			ST_SCAN: begin
				if (sts.ent_valid) state_d = ST_DOT;
				else if (sts.ent_last) state_d = ST_EMIT;
			end
			ST_DOT: begin
				if (!sts.dot_busy) state_d = sts.zero_norm ? ST_INSERT : ST_MULP;
			end
			ST_MULP: begin
				if (!sts.mul_busy) state_d = ST_MULR;
			end
			ST_MULR: begin
				if (!sts.mul_busy) state_d = ST_ROOT;
			end
			ST_ROOT: begin
				if (!sts.root_busy) state_d = ST_INSERT;
			end
			ST_INSERT: begin
				state_d = sts.ent_last ? ST_EMIT : ST_SCAN;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.emit_last) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		ctl = '0;
		case (state_q)
			ST_IDLE: begin
				ctl.take        = cmd_valid;
				ctl.search_init = cmd_valid && sts.qry_last;
			end
			ST_SCAN: begin
				if (sts.ent_valid) ctl.dot_start = 1'b1;
				else if (!sts.ent_last) ctl.scan_next = 1'b1;
			end
			ST_DOT: begin
				ctl.mul_start = !sts.dot_busy && !sts.zero_norm;
			end
			ST_MULP: begin
				ctl.mul_start = !sts.mul_busy;
				ctl.mul_sel_r = !sts.mul_busy;
			end
			ST_MULR: begin
				ctl.root_start = !sts.mul_busy;
			end
			ST_INSERT: begin
				ctl.insert    = 1'b1;
				ctl.scan_next = !sts.ent_last;
			end
			ST_EMIT: begin
				ctl.emit_load = sts.out_free;
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	assign cmd_stall = (state_q != ST_IDLE);

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.dot_start, ctl.mul_start, ctl.root_start, ctl.insert, ctl.emit_load}))
		else $error("more than one unit started");

	a_root_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ROOT) |-> !sts.mul_busy)
		else $error("multiplier busy during root search");

	a_insert_next: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |=> (state_q == ST_SCAN || state_q == ST_EMIT))
		else $error("bad state after insert");

endmodule

@@ hdl/ctks_dp.sv @@
module ctks_dp import ctks_pkg::*; #(
	parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
	parameter int MAX_DIM     = DEF_MAX_DIM,
	parameter int MAX_K       = DEF_MAX_K
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic [1:0]         func,
	input  logic [7:0]         entry_index,
	input  logic [9:0]         element_index,
	input  logic signed [15:0] element_value,
	input  logic               last_element,
	input  ctks_cmd_t          ctl,
	output ctks_sts_t          sts,
	input  logic               res_stall,
	output logic               res_valid,
	output logic [7:0]         match_index,
	output logic signed [15:0] similarity,
	output logic [16:0]        distance,
	output logic [3:0]         rank,
	output logic               found,
	output logic               last_result
);

	localparam int ENT_W  = $clog2(MAX_ENTRIES);
	localparam int DIX_W  = $clog2(MAX_DIM);
	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CNT_W  = $clog2(MAX_DIM + 2);
	localparam int DEPTH  = MAX_ENTRIES * MAX_DIM;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int AW     = 30 + DIM_W;
	localparam int MCW    = $clog2(AW);
	localparam int CW     = 2 * AW + 32;
	localparam int KC_W   = $clog2(MAX_K + 1);
	localparam int KI_W   = (MAX_K > 1) ? $clog2(MAX_K) : 1;

	// configuration
	logic [10:0]        dim_q;
	logic [4:0]         topk_q;
	logic signed [15:0] minsim_q;
	logic [DIM_W-1:0]   dim_eff;
	logic [KC_W-1:0]    k_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dim_q    <= DIM_RESET;
			topk_q   <= TOPK_RESET;
			minsim_q <= MINSIM_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_DIM:    dim_q    <= cfg_data[10:0];
				CFG_TOPK:   topk_q   <= cfg_data[4:0];
				CFG_MINSIM: minsim_q <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_comb begin
		if (dim_q == '0) dim_eff = DIM_W'(1);
		else if (32'(dim_q) > MAX_DIM) dim_eff = DIM_W'(MAX_DIM);
		else dim_eff = DIM_W'(dim_q);
		if (topk_q == '0) k_eff = KC_W'(1);
		else if (32'(topk_q) > MAX_K) k_eff = KC_W'(MAX_K);
		else k_eff = KC_W'(topk_q);
	end

	// input items
	logic               ent_in, elem_in;
	logic [ENT_W-1:0]   ent_a;
	logic [ADDR_W-1:0]  wr_addr;
	logic [CNT_W-1:0]   wr_cnt_q, wr_cnt_inc, q_cnt_q, q_cnt_inc;
	logic [7:0]         wr_ent_q;
	logic               wr_ok_q, wr_ok_n, wr_done_ok, q_ok_q, q_ok_n;
	logic               do_wr, do_rm, do_clr, do_qry;
	logic [MAX_ENTRIES-1:0] vld_q;

	assign ent_in  = 32'(entry_index) < MAX_ENTRIES;
	assign elem_in = 32'(element_index) < 32'(dim_eff);
	assign ent_a   = ENT_W'(entry_index);
	assign wr_addr = ADDR_W'(32'(ent_a) * MAX_DIM + 32'(element_index));

	assign do_wr  = ctl.take && (func == FN_WRITE);
	assign do_rm  = ctl.take && (func == FN_REMOVE);
	assign do_clr = ctl.take && (func == FN_CLEAR);
	assign do_qry = ctl.take && (func == FN_QUERY);

	assign wr_cnt_inc = (32'(wr_cnt_q) <= MAX_DIM) ? wr_cnt_q + 1'b1 : wr_cnt_q;
	assign wr_ok_n    = wr_ok_q && (wr_cnt_q == '0 || entry_index == wr_ent_q) &&
		(32'(element_index) == 32'(wr_cnt_q)) && ent_in;
	assign wr_done_ok = wr_ok_n && (32'(wr_cnt_inc) == 32'(dim_eff));

	assign q_cnt_inc = (32'(q_cnt_q) <= MAX_DIM) ? q_cnt_q + 1'b1 : q_cnt_q;
	assign q_ok_n    = q_ok_q && (32'(element_index) == 32'(q_cnt_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_cnt_q <= '0;
			wr_ok_q  <= 1'b1;
			wr_ent_q <= '0;
			q_cnt_q  <= '0;
			q_ok_q   <= 1'b1;
			vld_q    <= '0;
		end else begin
			if (do_wr) begin
				if (wr_cnt_q == '0) wr_ent_q <= entry_index;
				if (last_element) begin
					wr_cnt_q <= '0;
					wr_ok_q  <= 1'b1;
				end else begin
					wr_cnt_q <= wr_cnt_inc;
					wr_ok_q  <= wr_ok_n;
				end
				if (ent_in) vld_q[ent_a] <= last_element && wr_done_ok;
			end
			if (do_rm && ent_in) vld_q[ent_a] <= 1'b0;
			if (do_clr) vld_q <= '0;
			if (do_qry) begin
				if (last_element) begin
					q_cnt_q <= '0;
					q_ok_q  <= 1'b1;
				end else begin
					q_cnt_q <= q_cnt_inc;
					q_ok_q  <= q_ok_n;
				end
			end
		end
	end

	// scan over the table
	logic [ENT_W-1:0]  e_q;
	logic [ADDR_W-1:0] base_q;

	always_ff @(posedge clk) begin
		if (ctl.search_init) begin
			e_q    <= '0;
			base_q <= '0;
		end else if (ctl.scan_next) begin
			e_q    <= e_q + 1'b1;
			base_q <= base_q + ADDR_W'(MAX_DIM);
		end
	end

	// dot product and norms, one element per cycle
	logic signed [15:0] vec_mem [DEPTH];
	logic signed [15:0] qry_mem [MAX_DIM];
	logic               iss_q, v_s1, v_s2;
	logic [DIX_W-1:0]   ri_q;
	logic [ADDR_W-1:0]  raddr_q;
	logic signed [15:0] vrd_s1, qrd_s1;
	logic signed [31:0] pd, pa, pb;
	logic signed [31:0] pd_s2;
	logic [31:0]        pa_s2, pb_s2;
	logic signed [AW:0] dot_q;
	logic [AW-1:0]      na_q, nb_q, mag;
	logic               dot_busy, zero_norm;

	always_ff @(posedge clk) begin
		if (do_wr && ent_in && elem_in) vec_mem[wr_addr] <= element_value;
		if (do_qry && elem_in) qry_mem[DIX_W'(element_index)] <= element_value;
		if (iss_q) begin
			vrd_s1 <= vec_mem[raddr_q];
			qrd_s1 <= qry_mem[ri_q];
		end
	end

	assign pd = qrd_s1 * vrd_s1;
	assign pa = qrd_s1 * qrd_s1;
	assign pb = vrd_s1 * vrd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= 1'b0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
		end else begin
			v_s1 <= iss_q;
			v_s2 <= v_s1;
			if (ctl.dot_start) iss_q <= 1'b1;
			else if (iss_q && 32'(ri_q) == 32'(dim_eff) - 1) iss_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.dot_start) begin
			ri_q    <= '0;
			raddr_q <= base_q;
			dot_q   <= '0;
			na_q    <= '0;
			nb_q    <= '0;
		end else begin
			if (iss_q) begin
				ri_q    <= ri_q + 1'b1;
				raddr_q <= raddr_q + 1'b1;
			end
			if (v_s2) begin
				dot_q <= dot_q + (AW + 1)'(pd_s2);
				na_q  <= na_q + AW'(pa_s2);
				nb_q  <= nb_q + AW'(pb_s2);
			end
		end
		if (v_s1) begin
			pd_s2 <= pd;
			pa_s2 <= pa;
			pb_s2 <= pb;
		end
	end

	assign dot_busy  = iss_q | v_s1 | v_s2;
	assign zero_norm = (na_q == '0) || (nb_q == '0);
	assign mag       = dot_q[AW] ? AW'(-dot_q) : dot_q[AW-1:0];

	// shift-add multiplier: na*nb, then |dot|*|dot|
	logic              mbusy_q, msel_q;
	logic [MCW-1:0]    mcnt_q;
	logic [AW-1:0]     ma_q;
	logic [2*AW-1:0]   macc_q, macc_n;
	logic [AW:0]       msum;
	logic [2*AW-1:0]   p_q, r_q;

	assign msum   = {1'b0, macc_q[2*AW-1:AW]} + (macc_q[0] ? {1'b0, ma_q} : '0);
	assign macc_n = {msum, macc_q[AW-1:1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mbusy_q <= 1'b0;
		end else if (ctl.mul_start) begin
			mbusy_q <= 1'b1;
		end else if (mbusy_q && 32'(mcnt_q) == AW - 1) begin
			mbusy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.mul_start) begin
			msel_q <= ctl.mul_sel_r;
			mcnt_q <= '0;
			ma_q   <= ctl.mul_sel_r ? mag : na_q;
			macc_q <= {{AW{1'b0}}, (ctl.mul_sel_r ? mag : nb_q)};
		end else if (mbusy_q) begin
			mcnt_q <= mcnt_q + 1'b1;
			macc_q <= macc_n;
			if (32'(mcnt_q) == AW - 1) begin
				if (msel_q) r_q <= macc_n;
				else p_q <= macc_n;
			end
		end
	end

	// root search: largest t with t*t*P <= R*2^30, one bit per step (candidate phase, then compare phase)
	logic          rt_busy_q, ph_q;
	logic [3:0]    j_q;
	logic [15:0]   t_q;
	logic [CW-1:0] t2_q, tps_q, pj_q, cand_q, rc;

	assign rc = CW'({r_q, 30'b0});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rt_busy_q <= 1'b0;
			ph_q      <= 1'b0;
			j_q       <= '0;
			t_q       <= '0;
		end else if (ctl.root_start) begin
			rt_busy_q <= 1'b1;
			ph_q      <= 1'b0;
			j_q       <= 4'd15;
			t_q       <= '0;
		end else if (rt_busy_q) begin
			ph_q <= !ph_q;
			if (ph_q) begin
				if (cand_q <= rc) t_q <= t_q | (16'd1 << j_q);
				if (j_q == '0) rt_busy_q <= 1'b0;
				else j_q <= j_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.root_start) begin
			t2_q  <= '0;
			tps_q <= '0;
			pj_q  <= CW'(p_q) << 30;
		end else if (rt_busy_q) begin
			if (!ph_q) begin
				cand_q <= t2_q + tps_q + pj_q;
			end else begin
				if (cand_q <= rc) begin
					t2_q  <= cand_q;
					tps_q <= (tps_q >> 1) + pj_q;
				end else begin
					tps_q <= tps_q >> 1;
				end
				pj_q <= pj_q >> 2;
			end
		end
	end

	// similarity of the current entry
	logic signed [16:0] s17;
	logic signed [15:0] sim;
	logic               pass;

	always_comb begin
		s17 = dot_q[AW] ? -$signed({1'b0, t_q}) : $signed({1'b0, t_q});
		if (zero_norm) sim = SIM_ZERO;
		else if (s17 > 17'sd32767) sim = SIM_MAX;
		else sim = s17[15:0];
	end

	assign pass = sim >= minsim_q;

	// best list, kept sorted
	logic signed [15:0] bsim_q [MAX_K];
	logic [ENT_W-1:0]   bidx_q [MAX_K];
	logic [KC_W-1:0]    cnt_q;
	logic [MAX_K-1:0]   ge, km;
	logic               do_ins;

	always_comb begin
		for (int i = 0; i < MAX_K; i++) begin
			ge[i] = (KC_W'(i) < cnt_q) && (bsim_q[i] >= sim);
			km[i] = (KC_W'(i) == k_eff - 1'b1);
		end
	end

	assign do_ins = ctl.insert && pass && !(|(ge & km));

	for (genvar g = 0; g < MAX_K; g++) begin : g_slot
		logic signed [15:0] up_sim;
		logic [ENT_W-1:0]   up_idx;
		if (g == 0) begin : g_head
			assign up_sim = sim;
			assign up_idx = e_q;
		end else begin : g_tail
			assign up_sim = ge[g-1] ? sim : bsim_q[g-1];
			assign up_idx = ge[g-1] ? e_q : bidx_q[g-1];
		end
		always_ff @(posedge clk) begin
			if (do_ins && !ge[g]) begin
				bsim_q[g] <= up_sim;
				bidx_q[g] <= up_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.search_init) begin
			cnt_q <= '0;
		end else if (do_ins && cnt_q < k_eff) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// result register
	logic               res_valid_q, emit_last, none;
	logic [KC_W-1:0]    rk_q;
	logic signed [15:0] esim;
	logic [7:0]         match_q;
	logic signed [15:0] sim_q;
	logic [16:0]        dist_q;
	logic [3:0]         rank_q;
	logic               found_q, last_q;

	assign none      = (cnt_q == '0);
	assign emit_last = none || (rk_q + 1'b1 == cnt_q);
	assign esim      = bsim_q[rk_q[KI_W-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (ctl.emit_load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.search_init) begin
			rk_q <= '0;
		end else if (ctl.emit_load) begin
			rk_q    <= rk_q + 1'b1;
			match_q <= none ? 8'd0 : 8'(bidx_q[rk_q[KI_W-1:0]]);
			sim_q   <= none ? SIM_ZERO : esim;
			dist_q  <= none ? 17'd0 : {1'b0, SIM_ONE} - {esim[15], esim};
			rank_q  <= none ? 4'd0 : 4'(rk_q);
			found_q <= !none;
			last_q  <= emit_last;
		end
	end

	assign res_valid   = res_valid_q;
	assign match_index = match_q;
	assign similarity  = sim_q;
	assign distance    = dist_q;
	assign rank        = rank_q;
	assign found       = found_q;
	assign last_result = last_q;

	always_comb begin
		sts.qry_last  = (func == FN_QUERY) && last_element;
		sts.qry_ok    = q_ok_n && (32'(q_cnt_inc) == 32'(dim_eff));
		sts.ent_valid = vld_q[e_q];
		sts.ent_last  = (32'(e_q) == MAX_ENTRIES - 1);
		sts.dot_busy  = dot_busy;
		sts.zero_norm = zero_norm;
		sts.mul_busy  = mbusy_q;
		sts.root_busy = rt_busy_q;
		sts.out_free  = !res_valid_q || !res_stall;
		sts.emit_last = emit_last;
	end

	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= KC_W'(MAX_K))
		else $error("best list overfull");

	a_root_range: assert property (@(posedge clk) disable iff (!arst_n)
		!rt_busy_q |-> t_q <= SIM_ONE)
		else $error("root above one");

	a_units_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(dot_busy && mbusy_q))
		else $error("dot unit and multiplier overlap");

endmodule
